@@ sv/scf_pkg.sv @@
// Shared types and constants for the sphere contact force unit.
// Used by the square root and divider pipelines, the top level and the testbench.
`timescale 1ns / 1ps

package scf_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int HEAD_STAGES = 4;
  localparam int TAIL_STAGES = 9;
  localparam int LATENCY     = HEAD_STAGES + SQRT_STAGES + 1 + DIV_STAGES + TAIL_STAGES;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_STIFFNESS    = 3'd4,
    REG_DAMPING      = 3'd5,
    REG_MIN_DISTANCE = 3'd6
  } cfg_reg_t;

  localparam logic [30:0] STIFFNESS_RESET    = 31'd1310720;
  localparam logic [30:0] DAMPING_RESET      = 31'd32768;
  localparam logic [30:0] MIN_DISTANCE_RESET = 31'd1;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
    logic [2:0][30:0] dm;
    logic             live;
  } root_side_t;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
    logic [30:0]      pen;
    logic             near;
    logic             in_sphere;
  } div_side_t;

endpackage

@@ sv/scf_if.sv @@
// Handshake channels for device samples and force results.
// Depends on nothing beyond the language itself.
`timescale 1ns / 1ps

interface scf_sample_if;
  logic        valid;
  logic        ready;
  logic        sample_valid;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;

  modport source (output valid, sample_valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, sample_valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                output ready);
endinterface

interface scf_force_if;
  logic        valid;
  logic        ready;
  logic [31:0] force_x;
  logic [31:0] force_y;
  logic [31:0] force_z;
  logic        in_contact;

  modport source (output valid, force_x, force_y, force_z, in_contact, input ready);
  modport sink (input valid, force_x, force_y, force_z, in_contact, output ready);
endinterface

@@ sv/scf_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on scf_pkg for the stage count.
`timescale 1ns / 1ps

module scf_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  localparam int N = scf_pkg::SQRT_STAGES;

  logic [63:0] rem [1:N];
  logic [63:0] res [1:N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (N - 1 - j));
    logic [63:0] rin;
    logic [63:0] sin;
    logic [63:0] trial;
    if (j == 0) begin : g_first
      assign rin = x;
      assign sin = '0;
    end else begin : g_next
      assign rin = rem[j];
      assign sin = res[j];
    end
    assign trial = sin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[j+1] <= rin - trial;
          res[j+1] <= (sin >> 1) + BIT;
        end else begin
          rem[j+1] <= rin;
          res[j+1] <= sin >> 1;
        end
      end
    end
  end

  assign root = res[N][31:0];

endmodule

@@ sv/scf_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on scf_pkg for the stage count; the high part must be below the divisor.
`timescale 1ns / 1ps

module scf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_hi,
  input  logic [30:0] num_lo,
  input  logic [31:0] den,
  output logic [30:0] quo
);

  localparam int N = scf_pkg::DIV_STAGES;

  logic [31:0] r  [1:N];
  logic [30:0] lo [1:N];
  logic [30:0] q  [1:N];
  logic [31:0] dn [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] rin;
    logic [30:0] lin;
    logic [30:0] qin;
    logic [31:0] din;
    logic [32:0] r2;
    logic        take;
    if (k == 0) begin : g_first
      assign rin = num_hi;
      assign lin = num_lo;
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign rin = r[k];
      assign lin = lo[k];
      assign qin = q[k];
      assign din = dn[k];
    end
    assign r2   = {rin, lin[30]};
    assign take = r2 >= {1'b0, din};
    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= take ? 32'(r2 - {1'b0, din}) : r2[31:0];
        lo[k+1] <= {lin[29:0], 1'b0};
        q[k+1]  <= {qin[29:0], take};
        dn[k+1] <= din;
      end
    end
  end

  assign quo = q[N];

endmodule

@@ sv/sphere_contact_force_unit.sv @@
// Sphere contact force unit: penalty spring and damper against a configured sphere.
// Depends on scf_pkg, scf_if, scf_sqrt and scf_div.
//
//   channel   role    words
//   sample    sink    one device sample
//   result    source  one force per sample
//   cfg       write   one register per write
//
// One sample enters every cycle while no result waits untaken.
// The depth is set by the bit-serial square root and normal dividers.
// The whole pipeline halts while a result waits untaken; nothing is lost or repeated.
// Reset clears the valid bits and restores the register defaults.
`timescale 1ns / 1ps

module sphere_contact_force_unit (
  input  logic               clk,
  input  logic               rst,
  scf_sample_if.sink         sample,
  scf_force_if.source        result,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int LAT = scf_pkg::LATENCY;
  localparam int SQN = scf_pkg::SQRT_STAGES;
  localparam int DVN = scf_pkg::DIV_STAGES;

  logic signed [31:0] center [3];
  logic [30:0] radius;
  logic [30:0] stiffness;
  logic [30:0] damping;
  logic [30:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0]    <= '0;
      center[1]    <= '0;
      center[2]    <= '0;
      radius       <= '0;
      stiffness    <= scf_pkg::STIFFNESS_RESET;
      damping      <= scf_pkg::DAMPING_RESET;
      min_distance <= scf_pkg::MIN_DISTANCE_RESET;
    end else if (cfg_we) begin
      unique case (scf_pkg::cfg_reg_t'(cfg_index))
        scf_pkg::REG_CENTER_X:     center[0]    <= cfg_data;
        scf_pkg::REG_CENTER_Y:     center[1]    <= cfg_data;
        scf_pkg::REG_CENTER_Z:     center[2]    <= cfg_data;
        scf_pkg::REG_RADIUS:       radius       <= cfg_data[30:0];
        scf_pkg::REG_STIFFNESS:    stiffness    <= cfg_data[30:0];
        scf_pkg::REG_DAMPING:      damping      <= cfg_data[30:0];
        scf_pkg::REG_MIN_DISTANCE: min_distance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;

  assign en           = !vld[LAT-1] || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  logic signed [31:0] pos [3];
  logic [2:0][31:0] vel_in;
  assign pos[0] = sample.pos_x;
  assign pos[1] = sample.pos_y;
  assign pos[2] = sample.pos_z;
  assign vel_in = {sample.vel_z, sample.vel_y, sample.vel_x};

  logic signed [32:0] d1 [3];
  logic [2:0][31:0] vel1;
  logic ok1;
  logic [32:0] dm2 [3];
  logic [2:0] neg2;
  logic [2:0][31:0] vel2;
  logic live2;
  logic [61:0] sq3 [3];
  scf_pkg::root_side_t s3;
  logic [63:0] dist2;
  scf_pkg::root_side_t s4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= 33'(pos[i]) - 33'(center[i]);
      end
      vel1 <= vel_in;
      ok1  <= sample.sample_valid && (radius != '0);

      live2 <= ok1;
      vel2  <= vel1;
      for (int i = 0; i < 3; i++) begin
        dm2[i]  <= d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
        neg2[i] <= d1[i][32];
      end

      for (int i = 0; i < 3; i++) begin
        sq3[i]    <= dm2[i][30:0] * dm2[i][30:0];
        s3.dm[i]  <= dm2[i][30:0];
      end
      s3.vel  <= vel2;
      s3.neg  <= neg2;
      s3.live <= live2 && (dm2[0] < {2'b0, radius}) && (dm2[1] < {2'b0, radius})
                 && (dm2[2] < {2'b0, radius});

      dist2 <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
      s4    <= s3;
    end
  end

  logic [31:0] root;
  scf_pkg::root_side_t sd [SQN];

  scf_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (dist2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s4;
      for (int i = 1; i < SQN; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  scf_pkg::root_side_t sr;
  scf_pkg::div_side_t sa;
  logic [31:0] dist_a;
  logic [2:0][30:0] dm_a;

  assign sr = sd[SQN-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_a       <= root;
      dm_a         <= sr.dm;
      sa.vel       <= sr.vel;
      sa.neg       <= sr.neg;
      sa.pen       <= radius - root[30:0];
      sa.near      <= root <= {1'b0, min_distance};
      sa.in_sphere <= sr.live && (root < {1'b0, radius});
    end
  end

  logic [30:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    scf_div u_div (
      .clk    (clk),
      .en     (en),
      .num_hi ({2'b0, dm_a[i][30:1]}),
      .num_lo ({dm_a[i][0], 30'b0}),
      .den    (dist_a),
      .quo    (quo[i])
    );
  end

  scf_pkg::div_side_t dd [DVN];
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= sa;
      for (int i = 1; i < DVN; i++) begin
        dd[i] <= dd[i-1];
      end
    end
  end

  scf_pkg::div_side_t sq;
  assign sq = dd[DVN-1];

  logic signed [31:0] nb [3];
  logic [2:0][31:0] vel_b;
  logic [30:0] pen_b;
  logic in_b;
  logic signed [63:0] vp_c [3];
  logic signed [31:0] nc [3];
  logic [45:0] spring_c;
  logic in_c;
  logic signed [63:0] vsum_d;
  logic signed [31:0] nd [3];
  logic [45:0] spring_d;
  logic in_d;
  logic [32:0] vnm_e;
  logic vneg_e;
  logic signed [31:0] ne [3];
  logic [45:0] spring_e;
  logic in_e;
  logic [47:0] damp_f;
  logic vneg_f;
  logic signed [31:0] nf [3];
  logic [45:0] spring_f;
  logic in_f;
  logic signed [50:0] f_g;
  logic signed [31:0] ng [3];
  logic in_g;
  logic [49:0] fm_h;
  logic [30:0] nm_h [3];
  logic [2:0] neg_h;
  logic in_h;
  logic [50:0] hp_i [3];
  logic [60:0] lp_i [3];
  logic [2:0] neg_i;
  logic in_i;
  logic [31:0] force_j [3];
  logic in_j;

  function automatic logic [31:0] sat_force(input logic [51:0] m, input logic neg);
    logic [31:0] r;
    if (m == '0) begin
      r = '0;
    end else if (neg) begin
      r = (m >= 52'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
    end else begin
      r = (m > 52'h7fffffff) ? 32'h7fffffff : m[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (sq.near) begin
          nb[i] <= (i == 2) ? 32'sh40000000 : 32'sd0;
        end else begin
          nb[i] <= sq.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
        end
      end
      vel_b <= sq.vel;
      pen_b <= sq.pen;
      in_b  <= sq.in_sphere;

      for (int i = 0; i < 3; i++) begin
        vp_c[i] <= $signed(vel_b[i]) * nb[i];
        nc[i]   <= nb[i];
      end
      spring_c <= 46'((62'(stiffness) * 62'(pen_b)) >> 16);
      in_c     <= in_b;

      vsum_d   <= vp_c[0] + vp_c[1] + vp_c[2];
      nd       <= nc;
      spring_d <= spring_c;
      in_d     <= in_c;

      vneg_e   <= vsum_d[63];
      vnm_e    <= vsum_d[63] ? 33'(64'(-vsum_d) >> 30) : 33'(vsum_d >>> 30);
      ne       <= nd;
      spring_e <= spring_d;
      in_e     <= in_d;

      damp_f   <= 48'((64'(damping) * 64'(vnm_e)) >> 16);
      vneg_f   <= vneg_e;
      nf       <= ne;
      spring_f <= spring_e;
      in_f     <= in_e;

      f_g  <= vneg_f ? $signed(51'(spring_f) + 51'(damp_f))
                     : $signed(51'(spring_f) - 51'(damp_f));
      ng   <= nf;
      in_g <= in_f;

      fm_h <= f_g[50] ? 50'(-f_g) : 50'(f_g);
      for (int i = 0; i < 3; i++) begin
        nm_h[i]  <= ng[i][31] ? 31'(-ng[i]) : ng[i][30:0];
        neg_h[i] <= f_g[50] ^ ng[i][31];
      end
      in_h <= in_g;

      for (int i = 0; i < 3; i++) begin
        hp_i[i] <= fm_h[49:30] * nm_h[i];
        lp_i[i] <= fm_h[29:0] * nm_h[i];
      end
      neg_i <= neg_h;
      in_i  <= in_h;

      for (int i = 0; i < 3; i++) begin
        force_j[i] <= in_i ? sat_force(52'(hp_i[i]) + 52'(lp_i[i] >> 30), neg_i[i]) : '0;
      end
      in_j <= in_i;
    end
  end

  assign result.valid      = vld[LAT-1];
  assign result.force_x    = force_j[0];
  assign result.force_y    = force_j[1];
  assign result.force_z    = force_j[2];
  assign result.in_contact = in_j;

`ifndef NO_ASSERTIONS
  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.in_contact |->
      result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
    else $error("force without contact");

  a_contact_needs_radius: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.in_contact |-> radius != '0)
    else $error("contact with zero radius");

  a_stall_holds_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid straight after reset");
`endif

endmodule

@@ verif/scf_force_scoreboard.sv @@
// Scoreboard class for the sphere contact force unit testbench.
// Holds a copy of the registers, predicts forces and checks results; uses scf_pkg.
`timescale 1ns / 1ps

class scf_force_scoreboard;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        contact;
  } force_word_t;

  logic signed [31:0] ctr [3];
  logic [30:0] radius, stiff, damp_gain, min_dist;
  force_word_t pending_forces [$];
  int errors;

  function new();
    errors = 0;
    reset_regs();
  endfunction

  function void reset_regs();
    ctr[0] = 0;
    ctr[1] = 0;
    ctr[2] = 0;
    radius = 0;
    stiff = scf_pkg::STIFFNESS_RESET;
    damp_gain = scf_pkg::DAMPING_RESET;
    min_dist = scf_pkg::MIN_DISTANCE_RESET;
  endfunction

  function void write_reg(scf_pkg::cfg_reg_t idx, logic [31:0] data);
    case (idx)
      scf_pkg::REG_CENTER_X: ctr[0] = data;
      scf_pkg::REG_CENTER_Y: ctr[1] = data;
      scf_pkg::REG_CENTER_Z: ctr[2] = data;
      scf_pkg::REG_RADIUS: radius = data[30:0];
      scf_pkg::REG_STIFFNESS: stiff = data[30:0];
      scf_pkg::REG_DAMPING: damp_gain = data[30:0];
      scf_pkg::REG_MIN_DISTANCE: min_dist = data[30:0];
      default: ;
    endcase
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function logic [31:0] scale_clamp(logic signed [63:0] f, logic signed [63:0] n);
    logic [63:0] fm, nm, m;
    fm = f < 0 ? -f : f;
    nm = n < 0 ? -n : n;
    m = (fm >> 30) * nm + (((fm & 64'h3FFF_FFFF) * nm) >> 30);
    if (m == 0) return 0;
    if ((f < 0) != (n < 0)) begin
      if (m >= 64'h8000_0000) return 32'h8000_0000;
      return -m[31:0];
    end
    if (m > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function void note_sample(logic sv, logic [31:0] p [3], logic [31:0] v [3]);
    force_word_t w;
    logic signed [63:0] d [3], n [3];
    logic [63:0] dm [3], dist2, root_dist, pen, spring, dmp, vnm, q;
    logic signed [63:0] vsum, vn, f;
    logic outside;
    w = '{0, 0, 0, 0};
    outside = 0;
    dist2 = 0;
    vsum = 0;
    if (sv && radius != 0) begin
      for (int i = 0; i < 3; i++) begin
        d[i] = $signed(p[i]) - ctr[i];
        dm[i] = d[i] < 0 ? -d[i] : d[i];
        if (dm[i] >= radius) outside = 1;
        dist2 = dist2 + dm[i] * dm[i];
      end
      if (!outside) begin
        root_dist = int_sqrt(dist2);
        if (root_dist < radius) begin
          pen = radius - root_dist;
          for (int i = 0; i < 3; i++) begin
            if (root_dist > min_dist) begin
              q = (dm[i] << 30) / root_dist;
              n[i] = d[i] < 0 ? -$signed(q) : $signed(q);
            end else begin
              n[i] = (i == 2) ? 64'sd1 << 30 : 0;
            end
          end
          spring = (stiff * pen) >> 16;
          for (int i = 0; i < 3; i++) vsum = vsum + $signed(v[i]) * n[i];
          vnm = (vsum < 0 ? -vsum : vsum) >> 30;
          dmp = (damp_gain * vnm) >> 16;
          vn = vsum < 0 ? -$signed(dmp) : $signed(dmp);
          f = $signed(spring) - vn;
          w.fx = scale_clamp(f, n[0]);
          w.fy = scale_clamp(f, n[1]);
          w.fz = scale_clamp(f, n[2]);
          w.contact = 1;
        end
      end
    end
    pending_forces.push_back(w);
  endfunction

  function void check_force(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz, logic c);
    force_word_t e;
    if (pending_forces.size() == 0) begin
      $display("%0t: unexpected force word %h %h %h %b", $realtime, fx, fy, fz, c);
      errors++;
      return;
    end
    e = pending_forces.pop_front();
    if (e.fx !== fx) begin
      $display("%0t: force_x expected %h actual %h", $realtime, e.fx, fx);
      errors++;
    end
    if (e.fy !== fy) begin
      $display("%0t: force_y expected %h actual %h", $realtime, e.fy, fy);
      errors++;
    end
    if (e.fz !== fz) begin
      $display("%0t: force_z expected %h actual %h", $realtime, e.fz, fz);
      errors++;
    end
    if (e.contact !== c) begin
      $display("%0t: in_contact expected %b actual %b", $realtime, e.contact, c);
      errors++;
    end
  endfunction

endclass

@@ verif/testbench.sv @@
// Top-level testbench for sphere_contact_force_unit: directed and random samples.
// Depends on scf_pkg, scf_if, the scoreboard class and the unit under test.
`timescale 1ns / 1ps

module testbench;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic hold_off;
  int cycle_count;

  scf_sample_if sample ();
  scf_force_if result ();
  scf_force_scoreboard board;

  sphere_contact_force_unit dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("sphere_contact_force_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      board.check_force(result.force_x, result.force_y, result.force_z, result.in_contact);
  end

  initial begin
    int g;
    result.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        result.ready <= 0;
        repeat (300) @(posedge clk);
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          result.ready <= 0;
          repeat (g) @(posedge clk);
        end
        result.ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(scf_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_sample(logic sv, logic [31:0] p [3], logic [31:0] v [3], bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      sample.valid <= 0;
      repeat (g) @(posedge clk);
    end
    sample.valid <= 1;
    sample.sample_valid <= sv;
    sample.pos_x <= p[0];
    sample.pos_y <= p[1];
    sample.pos_z <= p[2];
    sample.vel_x <= v[0];
    sample.vel_y <= v[1];
    sample.vel_z <= v[2];
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    board.note_sample(sv, p, v);
  endtask

  task automatic drain();
    sample.valid <= 0;
    while (board.pending_forces.size() != 0) @(posedge clk);
    repeat (scf_pkg::LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_offset(logic [31:0] c, int unsigned r);
    int unsigned span;
    span = (r == 0) ? 1 : r;
    return c + $signed($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_phase(int count, int unsigned r);
    logic [31:0] p [3], v [3];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 9))
          0: p[i] = $urandom();
          1: v[i] = 0;
          default: ;
        endcase
        p[i] = ($urandom_range(0, 9) == 0) ? $urandom() : rand_offset(board.ctr[i], r);
        if ($urandom_range(0, 5) == 0) p[i] = board.ctr[i];
        v[i] = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 400000))
               - 200000;
      end
      send_sample($urandom_range(0, 15) != 0, p, v, 1);
    end
  endtask

  initial begin
    logic [31:0] p [3], v [3];
    board = new();
    rst = 1;
    cfg_we = 0;
    cfg_index = scf_pkg::REG_CENTER_X;
    cfg_data = 0;
    hold_off = 0;
    cycle_count = 0;
    sample.valid = 0;
    sample.sample_valid = 0;
    sample.pos_x = 0;
    sample.pos_y = 0;
    sample.pos_z = 0;
    sample.vel_x = 0;
    sample.vel_y = 0;
    sample.vel_z = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    p = '{0, 0, 0};
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_sample(1, p, v, 0);
    drain();
    write_reg(scf_pkg::REG_RADIUS, 32'h0002_0000);
    send_sample(1, p, v, 0);
    send_sample(0, p, v, 0);
    p = '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000};
    send_sample(1, p, v, 0);
    p = '{32'h0002_0000, 0, 0};
    send_sample(1, p, v, 0);
    p = '{32'h0001_8000, 32'h0001_8000, 0};
    send_sample(1, p, v, 0);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_sample(1, p, v, 0);
    p = '{0, 0, 32'hFFFF_0000};
    v = '{0, 0, 32'h8000_0000};
    send_sample(1, p, v, 0);
    drain();
    write_reg(scf_pkg::REG_CENTER_X, 32'h7FFF_0000);
    write_reg(scf_pkg::REG_CENTER_Y, 32'h8000_0000);
    write_reg(scf_pkg::REG_CENTER_Z, 32'h8000_1000);
    write_reg(scf_pkg::REG_RADIUS, 32'h7FFF_FFFF);
    write_reg(scf_pkg::REG_STIFFNESS, 32'h7FFF_FFFF);
    write_reg(scf_pkg::REG_DAMPING, 32'h7FFF_FFFF);
    write_reg(scf_pkg::REG_MIN_DISTANCE, 0);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_sample(1, p, v, 0);
    p = '{32'h0000_0000, 32'hC000_0000, 32'hC000_0000};
    send_sample(1, p, v, 0);
    p = '{32'h7FFF_0000, 32'h8000_0000, 32'h8000_1000};
    send_sample(1, p, v, 0);
    drain();

    write_reg(scf_pkg::REG_CENTER_X, $urandom());
    write_reg(scf_pkg::REG_CENTER_Y, $urandom());
    write_reg(scf_pkg::REG_CENTER_Z, $urandom());
    write_reg(scf_pkg::REG_RADIUS, 32'h0001_0000);
    write_reg(scf_pkg::REG_STIFFNESS, 32'h0050_0000);
    write_reg(scf_pkg::REG_DAMPING, 32'h0000_8000);
    write_reg(scf_pkg::REG_MIN_DISTANCE, 32'h0000_1000);
    hold_off = 1;
    fork
      random_phase(250, 32'h0001_2000);
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();

    write_reg(scf_pkg::REG_RADIUS, 32'h0100_0000);
    write_reg(scf_pkg::REG_STIFFNESS, $urandom_range(0, 32'h7FFF_FFFF));
    write_reg(scf_pkg::REG_DAMPING, 0);
    write_reg(scf_pkg::REG_MIN_DISTANCE, 32'h0080_0000);
    random_phase(250, 32'h0100_8000);
    drain();

    write_reg(scf_pkg::REG_CENTER_X, 0);
    write_reg(scf_pkg::REG_CENTER_Y, 0);
    write_reg(scf_pkg::REG_CENTER_Z, 0);
    write_reg(scf_pkg::REG_RADIUS, 32'h7FFF_FFFF);
    write_reg(scf_pkg::REG_STIFFNESS, 32'h7FFF_FFFF);
    write_reg(scf_pkg::REG_DAMPING, $urandom_range(0, 32'h7FFF_FFFF));
    write_reg(scf_pkg::REG_MIN_DISTANCE, 32'h7FFF_FFFF);
    random_phase(150, 32'h7FFF_FFFF);
    drain();
    write_reg(scf_pkg::REG_MIN_DISTANCE, 1);
    random_phase(250, 32'h7FFF_FFFF);
    drain();

    if (board.errors == 0) begin
      $display("sphere_contact_force_unit test passed");
    end else begin
      $display("sphere_contact_force_unit test failed");
    end
    $finish;
  end

endmodule
